// ===== rtl/tsl_pkg.sv =====
// ----------------------------------------------------------------------------
// tsl_pkg
// Shared types and constants for the triangle strip to list converter.
// ----------------------------------------------------------------------------
package tsl_pkg;

    localparam int WORD_W   = 16;
    localparam int INDEX_W  = 15;
    localparam int FLAG_BIT = 15;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    typedef logic [INDEX_W-1:0] vidx_t;

    typedef struct packed {
        vidx_t a;
        vidx_t b;
        vidx_t c;
    } tri_t;

    // One request's worth of triangles: one or two.
    typedef struct packed {
        logic two;
        tri_t first;
        tri_t second;
    } batch_t;

endpackage

// ===== rtl/triangle_strip_to_list.sv =====
// ----------------------------------------------------------------------------
// triangle_strip_to_list
// Converts triangle-strip index words into a stream of triangles.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------
//   input   | in_valid / in_ready  | strip_word[15:0], end_of_list
//   output  | out_valid/ out_ready | vert_a, vert_b, vert_c, run_end
//
// One request accepted per cycle while the batch queue has room; each
// request's triangles go through the batch queue into the output register.
// A final word can yield two triangles, which leave one after the other
// through the single output register; that register sets the output rate.
// rst_n clears the strip state, empties the queue and drops out_valid.
// Output stalls fill the four-entry queue, then drop in_ready.
// ----------------------------------------------------------------------------
module triangle_strip_to_list
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tsl_pkg::WORD_W-1:0]  strip_word,
    input  logic                        end_of_list,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tsl_pkg::vidx_t              vert_a,
    output tsl_pkg::vidx_t              vert_b,
    output tsl_pkg::vidx_t              vert_c,
    output logic                        run_end
);

    logic            take;
    logic            push;
    logic            pop;
    logic            q_not_empty;
    tsl_pkg::batch_t push_data;
    tsl_pkg::batch_t pop_data;

    assign take = in_valid && in_ready;

    tsl_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .word  (strip_word),
        .last  (end_of_list),
        .push  (push),
        .batch (push_data)
    );

    tsl_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .not_full  (in_ready),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    tsl_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (pop_data),
        .q_pop       (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .vert_a      (vert_a),
        .vert_b      (vert_b),
        .vert_c      (vert_c),
        .run_end     (run_end)
    );

endmodule

// ===== rtl/tsl_front.sv =====
// ----------------------------------------------------------------------------
// tsl_front
// Holds one word of lookahead, tracks the strip state and forms the
// triangles caused by each accepted request.
// ----------------------------------------------------------------------------
module tsl_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             take,
    input  logic [tsl_pkg::WORD_W-1:0]       word,
    input  logic                             last,
    output logic                             push,
    output tsl_pkg::batch_t                  batch
);

    logic [tsl_pkg::WORD_W-1:0] held_word_reg, held_word_next;
    logic                       held_valid_reg, held_valid_next;
    tsl_pkg::vidx_t             older_reg, older_next;
    tsl_pkg::vidx_t             newer_reg, newer_next;
    logic [1:0]                 count_reg, count_next;
    logic                       cw_reg, cw_next;

    logic           restart;
    logic [1:0]     cnt1, cnt2;
    logic           cw1, cw2;
    logic           made0, made1;
    tsl_pkg::vidx_t hv, cv, old1, new1;
    tsl_pkg::tri_t  t0, t1;

    always_comb
    begin
        hv      = held_word_reg[tsl_pkg::INDEX_W-1:0];
        cv      = word[tsl_pkg::INDEX_W-1:0];
        restart = held_word_reg[tsl_pkg::FLAG_BIT] & word[tsl_pkg::FLAG_BIT];

        // held word, processed with the new word as lookahead
        cnt1  = restart ? 2'd0 : count_reg;
        cw1   = restart ? 1'b1 : cw_reg;
        made0 = held_valid_reg && (cnt1 == 2'd2);
        t0.a  = cw1 ? older_reg : hv;
        t0.b  = newer_reg;
        t0.c  = cw1 ? hv : older_reg;
        if (held_valid_reg)
        begin
            old1 = newer_reg;
            new1 = hv;
            cw2  = made0 ? ~cw1 : cw1;
            cnt2 = made0 ? cnt1 : cnt1 + 2'd1;
        end
        else
        begin
            old1 = older_reg;
            new1 = newer_reg;
            cw2  = cw_reg;
            cnt2 = count_reg;
        end

        // final word, no restart test
        made1 = last && (cnt2 == 2'd2);
        t1.a  = cw2 ? old1 : cv;
        t1.b  = new1;
        t1.c  = cw2 ? cv : old1;

        push         = take && (made0 || made1);
        batch.two    = made0 && made1;
        batch.first  = made0 ? t0 : t1;
        batch.second = t1;

        held_word_next  = held_word_reg;
        held_valid_next = held_valid_reg;
        older_next      = older_reg;
        newer_next      = newer_reg;
        count_next      = count_reg;
        cw_next         = cw_reg;
        if (take)
        begin
            if (last)
            begin
                held_word_next  = '0;
                held_valid_next = 1'b0;
                older_next      = '0;
                newer_next      = '0;
                count_next      = 2'd0;
                cw_next         = 1'b1;
            end
            else
            begin
                held_word_next  = word;
                held_valid_next = 1'b1;
                older_next      = old1;
                newer_next      = new1;
                count_next      = cnt2;
                cw_next         = cw2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_word_reg  <= '0;
            held_valid_reg <= 1'b0;
            older_reg      <= '0;
            newer_reg      <= '0;
            count_reg      <= 2'd0;
            cw_reg         <= 1'b1;
        end
        else
        begin
            held_word_reg  <= held_word_next;
            held_valid_reg <= held_valid_next;
            older_reg      <= older_next;
            newer_reg      <= newer_next;
            count_reg      <= count_next;
            cw_reg         <= cw_next;
        end
    end

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("vertex count past saturation");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !held_valid_reg |-> (count_reg == 2'd0 && cw_reg))
        else $error("strip state not clean with nothing held");

endmodule

// ===== rtl/tsl_queue.sv =====
// ----------------------------------------------------------------------------
// tsl_queue
// Small FIFO of triangle batches between the front and back parts.
// ----------------------------------------------------------------------------
module tsl_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tsl_pkg::batch_t push_data,
    output logic            not_full,
    input  logic            pop,
    output logic            not_empty,
    output tsl_pkg::batch_t pop_data
);

    tsl_pkg::batch_t                mem_reg [tsl_pkg::Q_DEPTH];
    logic [tsl_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tsl_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tsl_pkg::Q_CNT_W-1:0]    count_reg, count_next;

    localparam logic [tsl_pkg::Q_PTR_W-1:0] LAST_PTR = tsl_pkg::Q_PTR_W'(tsl_pkg::Q_DEPTH - 1);
    localparam logic [tsl_pkg::Q_CNT_W-1:0] FULL_CNT = tsl_pkg::Q_CNT_W'(tsl_pkg::Q_DEPTH);

    assign not_full  = count_reg != FULL_CNT;
    assign not_empty = count_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (not_full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

// ===== rtl/tsl_back.sv =====
// ----------------------------------------------------------------------------
// tsl_back
// Output register: takes batches from the queue and hands out their
// triangles one at a time, flagging the last of each batch.
// ----------------------------------------------------------------------------
module tsl_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_not_empty,
    input  tsl_pkg::batch_t q_data,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output tsl_pkg::vidx_t  vert_a,
    output tsl_pkg::vidx_t  vert_b,
    output tsl_pkg::vidx_t  vert_c,
    output logic            run_end
);

    logic            busy_reg, busy_next;
    logic            phase_reg, phase_next;
    tsl_pkg::batch_t batch_reg, batch_next;
    tsl_pkg::tri_t   cur;
    logic            done;

    always_comb
    begin
        cur       = phase_reg ? batch_reg.second : batch_reg.first;
        run_end   = !batch_reg.two || phase_reg;
        out_valid = busy_reg;
        vert_a    = cur.a;
        vert_b    = cur.b;
        vert_c    = cur.c;
        done      = busy_reg && out_ready && run_end;
        q_pop     = q_not_empty && (!busy_reg || done);

        busy_next  = busy_reg;
        phase_next = phase_reg;
        batch_next = batch_reg;
        if (q_pop)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            batch_next = q_data;
        end
        else if (done)
        begin
            busy_next  = 1'b0;
            phase_next = 1'b0;
        end
        else if (busy_reg && out_ready)
            phase_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        batch_reg <= batch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (busy_reg && batch_reg.two))
        else $error("second triangle selected without a pair");

    a_pair_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_ready && !run_end) |=> (busy_reg && phase_reg))
        else $error("pair did not advance to second triangle");

endmodule

// ===== tb/triangle_strip_to_list_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_strip_to_list_test
// Self-checking bench for the strip-to-list converter. Drives strips with
// restart pairs, end-of-list words and noise through four idle/stall phases
// plus one long output hold-off, and checks every triangle in order against
// a behavioral predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module triangle_strip_to_list_test;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 480;
    localparam int DRAIN_CYCLES    = 8;

    typedef struct {
        tsl_pkg::vidx_t a;
        tsl_pkg::vidx_t b;
        tsl_pkg::vidx_t c;
        logic           run_end;
    } tri_due_t;

    class strip_book;
        logic [tsl_pkg::WORD_W-1:0] held_word;
        bit                         held_valid;
        tsl_pkg::vidx_t             older_v;
        tsl_pkg::vidx_t             newer_v;
        int unsigned                vcount;
        bit                         cw;
        tri_due_t                   due_q[$];
        int                         mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            held_word  = '0;
            held_valid = 0;
            older_v    = '0;
            newer_v    = '0;
            vcount     = 0;
            cw         = 1;
        endfunction

        function bit take_vertex(logic [tsl_pkg::WORD_W-1:0] w, bit restart,
                                 output tri_due_t t);
            tsl_pkg::vidx_t v;
            bit             made;
            v    = w[tsl_pkg::INDEX_W-1:0];
            made = 0;
            t    = '{default: '0};
            if (restart)
            begin
                vcount = 0;
                cw     = 1;
            end
            if (vcount >= 2)
            begin
                if (cw)
                    t = '{a: older_v, b: newer_v, c: v, run_end: 1'b0};
                else
                    t = '{a: v, b: newer_v, c: older_v, run_end: 1'b0};
                cw   = !cw;
                made = 1;
            end
            else
                vcount++;
            older_v = newer_v;
            newer_v = v;
            return made;
        endfunction

        function void note_request(logic [tsl_pkg::WORD_W-1:0] w, logic is_last);
            tri_due_t t;
            tri_due_t made_q[$];
            if (held_valid)
            begin
                if (take_vertex(held_word,
                                held_word[tsl_pkg::FLAG_BIT] & w[tsl_pkg::FLAG_BIT], t))
                    made_q = {made_q, t};
            end
            if (is_last)
            begin
                if (take_vertex(w, 1'b0, t))
                    made_q = {made_q, t};
                clear();
            end
            else
            begin
                held_word  = w;
                held_valid = 1;
            end
            if (made_q.size() > 0)
                made_q[made_q.size()-1].run_end = 1'b1;
            foreach (made_q[i])
                due_q = {due_q, made_q[i]};
        endfunction

        function void check_triangle(tsl_pkg::vidx_t a, tsl_pkg::vidx_t b,
                                     tsl_pkg::vidx_t c, logic re);
            tri_due_t t;
            if (due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR %0t: unexpected triangle a=%h b=%h c=%h run_end=%b",
                             $realtime, a, b, c, re);
            end
            else
            begin
                t = due_q.pop_front();
                if (a !== t.a || b !== t.b || c !== t.c || re !== t.run_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("ERROR %0t: exp a=%h b=%h c=%h run_end=%b", $realtime,
                               t.a, t.b, t.c, t.run_end);
                        $display(" got a=%h b=%h c=%h run_end=%b", a, b, c, re);
                    end
                end
            end
        endfunction
    endclass

    bit                         clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [tsl_pkg::WORD_W-1:0] strip_word;
    logic                       end_of_list;
    logic                       out_valid;
    logic                       out_ready;
    tsl_pkg::vidx_t             vert_a;
    tsl_pkg::vidx_t             vert_b;
    tsl_pkg::vidx_t             vert_c;
    logic                       run_end;

    strip_book book;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    bit        long_hold     = 0;
    int        cycle_count   = 0;

    triangle_strip_to_list DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .strip_word  (strip_word),
        .end_of_list (end_of_list),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .vert_a      (vert_a),
        .vert_b      (vert_b),
        .vert_c      (vert_c),
        .run_end     (run_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                book.note_request(strip_word, end_of_list);
            if (out_valid && out_ready)
                book.check_triangle(vert_a, vert_b, vert_c, run_end);
        end
    end

    // output side: random stalls, or one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic offer_word(logic [tsl_pkg::WORD_W-1:0] w, logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        strip_word  <= w;
        end_of_list <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic run_strip(logic [tsl_pkg::WORD_W-1:0] words[$]);
        foreach (words[i])
            offer_word(words[i], i == words.size() - 1);
    endtask

    function automatic tsl_pkg::vidx_t pick_index();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return tsl_pkg::vidx_t'($urandom_range(0, 32767));
    endfunction

    // lists of random length; restart pairs appear because a flag is likelier
    // after a flagged word; some lists are pure noise
    task automatic send_random_lists(int target);
        logic [tsl_pkg::WORD_W-1:0] words[$];
        logic [tsl_pkg::WORD_W-1:0] w_new;
        int                         done;
        int                         n;
        bit                         noisy;
        bit                         flag;
        done = 0;
        while (done < target)
        begin
            words.delete();
            noisy = ($urandom_range(0, 99) < 15);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            flag = 0;
            for (int i = 0; i < n; i++)
            begin
                if (noisy)
                    flag = 1'($urandom_range(0, 1));
                else
                    flag = ($urandom_range(0, 99) < (flag ? 50 : 10));
                w_new = {flag, pick_index()};
                words = {words, w_new};
            end
            run_strip(words);
            done += n;
        end
    endtask

    initial
    begin
        book        = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        strip_word  = '0;
        end_of_list = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone final word, too short, one triangle, flagged extremes,
        // restart inside a strip, flagged final word with no lookahead
        run_strip({16'h7FFF});
        run_strip({16'h0000, 16'h7FFF});
        run_strip({16'h0001, 16'h0002, 16'h0003});
        run_strip({16'h8005, 16'h8006, 16'h7FFF, 16'h0000, 16'hFFFF});
        run_strip({16'h0001, 16'h0002, 16'h0003, 16'h8004, 16'h8005, 16'h0006, 16'h7FFE});
        run_strip({16'h8001, 16'h8002, 16'h8003});

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                    long_hold    <= 1'b1;
                end
                1:
                begin
                    send_idle_pct = 82;
                    stall_pct    <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 82;
                end
                default:
                begin
                    send_idle_pct = 12;
                    stall_pct    <= 12;
                end
            endcase
            send_random_lists(ITEMS_PER_PHASE);
        end
        in_valid <= 1'b0;

        while (book.due_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (book.mismatches == 0 && book.due_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
